// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. Clock is clk, disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LLR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/llr_pkg.sv =====
package llr_pkg;

  // field widths of the item channels
  localparam int OP_W    = 1;
  localparam int BYTE_W  = 8;
  localparam int LIDX_W  = 5;
  localparam int CIDX_W  = 7;
  localparam int COUNT_W = 6;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 1'b0;
  localparam logic [OP_W-1:0] OP_READ   = 1'b1;

  // control characters
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

endpackage

// ===== src/llr_in_if.sv =====
interface llr_in_if;
  import llr_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] data_byte;
  logic [LIDX_W-1:0] line_index;
  logic [CIDX_W-1:0] char_index;

  modport source (output valid, output op, output data_byte, output line_index,
                  output char_index, input ready);
  modport sink   (input valid, input op, input data_byte, input line_index,
                  input char_index, output ready);
endinterface

// ===== src/llr_out_if.sv =====
interface llr_out_if;
  import llr_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  read_char;
  logic [COUNT_W-1:0] line_count;

  modport source (output valid, output read_char, output line_count, input ready);
  modport sink   (input valid, input read_char, input line_count, output ready);
endinterface

// ===== src/llr_ram.sv =====
// Simple dual-port RAM, one write and one read port, registered read data.
module llr_ram #(
  parameter int AW = 5,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [0:(1 << AW) - 1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== src/line_assembling_ring_log_core.sv =====
// Line-assembling ring log. Text bytes (op append) build the current line
// straight into a spare physical slot of the character memory; carriage
// returns are ignored, bytes past LINE_LEN-1 are dropped and a stored line
// ends at its first zero byte. A newline commits the line: a slot table maps
// each ring position to a physical slot and its length, and when the ring is
// full the oldest line's physical slot is recycled as the next spare, so no
// copy is ever made. A read item (op read) returns one character of the
// line line_index places after the oldest, or 0 out of range, plus the line
// count. An append or an out-of-range read goes from idle to the result
// state; a newline passes the commit state, which uses the registered table
// read, and an in-range read the lookup state, which reads the character
// memory at the registered table entry. One item is in flight at a time;
// the result register lets the next item be taken while the previous
// result waits. No clearing pass after reset: unwritten memory data is never used.
`include "assert_macros.svh"

module line_assembling_ring_log_core #(
  parameter int NUM_LINES = 32,
  parameter int LINE_LEN  = 128
) (
  input logic       clk,
  input logic       rst,
  llr_in_if.sink    req,
  llr_out_if.source rsp
);
  import llr_pkg::*;

  localparam int SW   = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1; // ring position
  localparam int CNW  = $clog2(NUM_LINES + 1);                    // count
  localparam int PW   = CNW;                                      // physical slot, N+1 of them
  localparam int LW   = $clog2(LINE_LEN);                         // column / length
  localparam int LCW  = (CNW > LIDX_W) ? CNW : LIDX_W;
  localparam int SUMW = LCW + 1;
  localparam int CIW  = (LW > CIDX_W) ? LW : CIDX_W;
  localparam int TW   = PW + LW;                                  // table entry {phys, len}

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOKUP = 4'b0010,
    S_COMMIT = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t state, state_next;

  // ring control
  logic [SW-1:0]  oldest;
  logic [CNW-1:0] count;
  logic [PW-1:0]  spare;      // physical slot the current line is built in
  logic [LW-1:0]  build_len;  // bytes taken, capped at LINE_LEN-1
  logic [LW-1:0]  line_len;   // bytes before the first zero
  logic           zero_seen;

  // item being worked on
  logic [OP_W-1:0] op_q;
  logic [CIW-1:0]  ci_q;
  logic            char_hit;

  // result register
  logic               out_valid;
  logic [BYTE_W-1:0]  read_char;
  logic [COUNT_W-1:0] line_count;

  logic            accept;
  logic            full;
  logic            is_text;
  logic            room;
  logic            line_hit;
  logic [SUMW-1:0] rd_sum;
  logic [SUMW-1:0] rd_wrap;
  logic [SW-1:0]   rd_slot;
  logic            load_out;

  // slot table
  logic          tbl_we;
  logic [SW-1:0] tbl_waddr;
  logic [TW-1:0] tbl_wdata;
  logic          tbl_re;
  logic [SW-1:0] tbl_raddr;
  logic [TW-1:0] tbl_rdata;

  // character memory, addressed {phys, column}
  logic               st_we;
  logic [PW+LW-1:0]   st_waddr;
  logic               st_re;
  logic [PW+LW-1:0]   st_raddr;
  logic [BYTE_W-1:0]  st_rdata;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = (count == CNW'(NUM_LINES));

  assign is_text = (req.data_byte != CH_CR) && (req.data_byte != CH_LF);
  assign room    = (build_len != LW'(LINE_LEN - 1));

  // ring position of a read: (oldest + line_index) mod NUM_LINES, sum < 2N when in range
  assign line_hit = LCW'(req.line_index) < LCW'(count);
  assign rd_sum   = SUMW'(oldest) + SUMW'(req.line_index);
  assign rd_wrap  = (rd_sum >= SUMW'(NUM_LINES)) ? rd_sum - SUMW'(NUM_LINES) : rd_sum;
  assign rd_slot  = rd_wrap[SW-1:0];

  // table: read on accept (read hit, or newline for the evicted entry), write on commit.
  // Oldest is 0 until the ring fills, so the free position is the count itself.
  assign tbl_re    = accept && ((req.op == OP_READ) ? line_hit : (req.data_byte == CH_LF));
  assign tbl_raddr = (req.op == OP_READ) ? rd_slot : oldest;
  assign tbl_we    = (state == S_COMMIT);
  assign tbl_waddr = full ? oldest : count[SW-1:0];
  assign tbl_wdata = {spare, line_len};

  // text bytes go straight into the spare slot
  assign st_we    = accept && (req.op == OP_APPEND) && is_text && room;
  assign st_waddr = {spare, build_len};
  assign st_re    = (state == S_LOOKUP);
  assign st_raddr = {tbl_rdata[LW +: PW], ci_q[LW-1:0]};

  llr_ram #(.AW(SW), .DW(TW)) u_slot_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  llr_ram #(.AW(PW + LW), .DW(BYTE_W)) u_char_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (req.data_byte),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign load_out = (state == S_RESULT) && (!out_valid || rsp.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.op == OP_READ) begin
            state_next = line_hit ? S_LOOKUP : S_RESULT;
          end else if (req.data_byte == CH_LF) begin
            state_next = S_COMMIT;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_LOOKUP: state_next = S_RESULT;
      S_COMMIT: state_next = S_RESULT;
      S_RESULT: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      oldest    <= '0;
      count     <= '0;
      spare     <= '0;
      build_len <= '0;
      line_len  <= '0;
      zero_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (st_we) begin
        build_len <= build_len + LW'(1);
        if (!zero_seen) begin
          if (req.data_byte == '0) begin
            zero_seen <= 1'b1;
          end else begin
            line_len <= line_len + LW'(1);
          end
        end
      end

      // commit: table data holds the entry at the oldest position
      if (state == S_COMMIT) begin
        if (full) begin
          spare  <= tbl_rdata[LW +: PW];
          oldest <= (oldest == SW'(NUM_LINES - 1)) ? '0 : oldest + SW'(1);
        end else begin
          count <= count + CNW'(1);
          spare <= spare + PW'(1);
        end
        build_len <= '0;
        line_len  <= '0;
        zero_seen <= 1'b0;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= req.op;
      ci_q     <= CIW'(req.char_index);
      char_hit <= 1'b0;
    end else if (state == S_LOOKUP) begin
      char_hit <= ci_q < CIW'(tbl_rdata[LW-1:0]);
    end
    if (load_out) begin
      read_char  <= ((op_q == OP_READ) && char_hit) ? st_rdata : '0;
      line_count <= COUNT_W'(count);
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_char  = read_char;
  assign rsp.line_count = line_count;

  // checks
  `LLR_ASSERT_IMPL(a_count_max, 1'b1, count <= CNW'(NUM_LINES), "line count above ring size")
  `LLR_ASSERT_IMPL(a_spare_fresh, !full, spare == PW'(count), "spare slot not the next fresh one")
  `LLR_ASSERT_IMPL(a_oldest_zero, !full, oldest == '0, "oldest moved before ring filled")
  `LLR_ASSERT_NEXT(a_result_once, load_out, state == S_IDLE && out_valid, "result not posted")
endmodule

// ===== sim/line_assembling_ring_log_core_tb.sv =====
module line_assembling_ring_log_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import llr_pkg::*;

  localparam int NUM_LINES = 32;
  localparam int LINE_LEN  = 128;
  localparam int IDLE_PCT  = 22;   // chance of an idle cycle, per side, in percent
  localparam int MAX_SHOWN = 10;   // mismatches printed in full

  // one request item and one result item, at the block's field widths
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data_byte;
    logic [LIDX_W-1:0] line_index;
    logic [CIDX_W-1:0] char_index;
  } log_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_char;
    logic [COUNT_W-1:0] line_count;
  } log_rsp_t;

  logic clk;
  logic rst;

  llr_in_if  req_if ();
  llr_out_if rsp_if ();

  line_assembling_ring_log_core #(
    .NUM_LINES (NUM_LINES),
    .LINE_LEN  (LINE_LEN)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  // clock and the single reset at the start
  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Log predictor: own copy of the ring, the line being built and the counters
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] ring_chars [NUM_LINES][LINE_LEN];
  int unsigned       ring_len   [NUM_LINES];
  int unsigned       oldest_pos;
  int unsigned       lines_held;
  logic [BYTE_W-1:0] build_chars [LINE_LEN];
  int unsigned       build_len;

  // results owed by the block, oldest first
  log_rsp_t expected_results[$];

  int   fail_count;
  bit   no_idle;      // set for the back-to-back stretch
  int   rx_hold_len;  // length of the next receiver hold-off, in cycles
  bit   rx_hold_on;   // high while the hold-off process is counting
  event rx_hold_go;   // starts a hold-off

  // Store the line being built into the ring. A full ring drops its oldest
  // line; the stored copy ends at the first zero byte.
  function automatic void commit_built_line();
    int unsigned slot;
    int unsigned n;
    if (lines_held < NUM_LINES) begin
      slot = (oldest_pos + lines_held) % NUM_LINES;
      lines_held++;
    end else begin
      slot = oldest_pos;
      oldest_pos = (oldest_pos + 1) % NUM_LINES;
    end
    n = 0;
    while (n < build_len && build_chars[n] != '0) begin
      ring_chars[slot][n] = build_chars[n];
      n++;
    end
    ring_len[slot] = n;
    build_len = 0;
  endfunction

  // Expected result of one accepted item; updates the predicted log state.
  function automatic log_rsp_t apply_to_log(log_req_t r);
    log_rsp_t    res;
    int unsigned slot;
    res.read_char = '0;
    if (r.op == OP_APPEND) begin
      if (r.data_byte == CH_CR) begin
        // carriage return: no effect
      end else if (r.data_byte == CH_LF) begin
        commit_built_line();
      end else if (build_len < LINE_LEN - 1) begin
        build_chars[build_len] = r.data_byte;
        build_len++;
      end
      // characters past LINE_LEN-1 fall on the floor
    end else if (r.line_index < lines_held) begin
      slot = (oldest_pos + r.line_index) % NUM_LINES;
      if (r.char_index < ring_len[slot])
        res.read_char = ring_chars[slot][r.char_index];
    end
    res.line_count = COUNT_W'(lines_held);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: checks each accepted result, then picks next cycle's ready
  // ---------------------------------------------------------------------------
  function automatic void note_failure(string what, int want, int got);
    if (fail_count < MAX_SHOWN)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    fail_count++;
  endfunction

  // receiver hold-off, counted in cycles
  always begin
    @(rx_hold_go);
    rx_hold_on = 1'b1;
    repeat (rx_hold_len) @(posedge clk);
    rx_hold_on = 1'b0;
  end

  always @(posedge clk) begin
    log_rsp_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          if (fail_count < MAX_SHOWN)
            $display("[%0t] result with nothing outstanding: char %0d, count %0d",
                     $time, rsp_if.read_char, rsp_if.line_count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (rsp_if.read_char !== want.read_char)
            note_failure("read_char", want.read_char, rsp_if.read_char);
          if (rsp_if.line_count !== want.line_count)
            note_failure("line_count", want.line_count, rsp_if.line_count);
        end
      end
      // long hold-off first, else random idling unless in the back-to-back stretch
      if (rx_hold_on) begin
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. Every task is entered and left at a rising edge.
  // ---------------------------------------------------------------------------

  // Offer one item, with a random idle gap ahead of it, and wait until it is
  // taken. valid stays high on return so back-to-back items never toggle it.
  task automatic send_item(input log_req_t item);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.op         <= item.op;
    req_if.data_byte  <= item.data_byte;
    req_if.line_index <= item.line_index;
    req_if.char_index <= item.char_index;
    do @(posedge clk); while (!req_if.ready);
    expected_results.push_back(apply_to_log(item));
  endtask

  // unused fields carry random values so their bits toggle too
  task automatic send_char(input logic [BYTE_W-1:0] ch);
    log_req_t item;
    item.op         = OP_APPEND;
    item.data_byte  = ch;
    item.line_index = LIDX_W'($urandom);
    item.char_index = CIDX_W'($urandom);
    send_item(item);
  endtask

  task automatic send_read(input int unsigned li, input int unsigned ci);
    log_req_t item;
    item.op         = OP_READ;
    item.data_byte  = BYTE_W'($urandom);
    item.line_index = LIDX_W'(li);
    item.char_index = CIDX_W'(ci);
    send_item(item);
  endtask

  // sender goes quiet until the block has answered everything
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Random text byte: mostly printable, now and then CR, a zero or anything
  // but a newline.
  function automatic logic [BYTE_W-1:0] random_text_char();
    int unsigned pick;
    logic [BYTE_W-1:0] ch;
    pick = $urandom_range(99);
    if (pick < 80)      ch = BYTE_W'($urandom_range(8'h20, 8'h7E));
    else if (pick < 88) ch = CH_CR;
    else if (pick < 92) ch = '0;
    else begin
      ch = BYTE_W'($urandom);
      if (ch == CH_LF) ch = 8'h8A;
    end
    return ch;
  endfunction

  // Mix of whole lines, read bursts aimed at stored lines, and noise.
  // Returns having sent about n_items counted items.
  task automatic send_random_mix(input int n_items);
    int sent;
    int pick;
    int n_chars;
    int n_reads;
    int li;
    int ci;
    logic [BYTE_W-1:0] ch;
    log_req_t noise;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // one line; a few overlong ones run past the line length
        n_chars = ($urandom_range(99) < 4) ? $urandom_range(LINE_LEN - 8, LINE_LEN + 12)
                                           : $urandom_range(0, 12);
        repeat (n_chars) begin
          ch = random_text_char();
          send_char(ch);
          if (ch != CH_CR) sent++;
        end
        send_char(CH_LF);
        sent++;
      end else if (pick < 90) begin
        // reads, mostly inside a stored line or just past its end
        n_reads = $urandom_range(1, 6);
        repeat (n_reads) begin
          if (lines_held > 0 && $urandom_range(99) < 85) begin
            li = $urandom_range(lines_held - 1);
            ci = ($urandom_range(99) < 80)
                 ? $urandom_range(ring_len[(oldest_pos + li) % NUM_LINES] + 1)
                 : $urandom_range(LINE_LEN - 1);
          end else begin
            li = $urandom_range(NUM_LINES - 1);
            ci = $urandom_range(LINE_LEN - 1);
          end
          send_read(li, ci);
          sent++;
        end
      end else begin
        noise = ($bits(log_req_t))'($urandom);
        send_item(noise);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reads on an empty log answer 0 with a count of 0
  task automatic test_empty_log();
    send_read(0, 0);
    send_read(NUM_LINES - 1, LINE_LEN - 1);
  endtask

  // CR ignored, empty line, zero byte cutting a line short, reads in and out
  // of range, extreme field values
  task automatic test_line_basics();
    send_char(8'hFF);
    send_char(8'h01);
    send_char(CH_CR);
    send_char(8'h7F);
    send_char(CH_LF);
    send_char(CH_LF);              // empty line
    send_char(8'h78);
    send_char(8'h00);              // stored line stops here
    send_char(8'h79);
    send_char(CH_LF);
    send_read(0, 0);
    send_read(0, 2);
    send_read(0, 3);               // just past the end
    send_read(1, 0);               // empty line
    send_read(2, 0);
    send_read(2, 1);               // at the zero byte
    send_read(2, 2);
    send_read(3, 0);               // line index equal to the count
    send_read(NUM_LINES - 1, LINE_LEN - 1);
  endtask

  // enough short lines to fill the ring and overwrite the oldest several times
  task automatic test_ring_wrap();
    repeat (NUM_LINES + 8) begin
      repeat ($urandom_range(0, 3)) send_char(BYTE_W'($urandom_range(8'h21, 8'h7E)));
      send_char(CH_LF);
    end
    send_read(0, 0);
    send_read(NUM_LINES - 1, 0);
    send_read(NUM_LINES - 1, 1);
  endtask

  // receiver holds off for a long stretch while items keep coming, so the
  // block backs up and stalls its input
  task automatic test_output_stall();
    rx_hold_len = 150;
    -> rx_hold_go;
    repeat (12) send_char(BYTE_W'($urandom_range(8'h20, 8'h7E)));
    send_char(CH_LF);
    send_read(lines_held - 1, 0);
  endtask

  // sender goes quiet until every result is in, then carries on
  task automatic test_drain_pause();
    send_random_mix(20);
    wait_for_results();
    send_random_mix(20);
  endtask

  // neither side idles for a while
  task automatic test_back_to_back();
    no_idle = 1'b1;
    send_random_mix(60);
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    send_random_mix(220);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    fail_count   = 0;
    no_idle      = 1'b0;
    rx_hold_len  = 0;
    oldest_pos   = 0;
    lines_held   = 0;
    build_len    = 0;
    req_if.valid      <= 1'b0;
    req_if.op         <= OP_APPEND;
    req_if.data_byte  <= '0;
    req_if.line_index <= '0;
    req_if.char_index <= '0;

    @(posedge clk);
    while (rst) @(posedge clk);

    test_empty_log();
    test_line_basics();
    test_ring_wrap();
    test_output_stall();
    test_drain_pause();
    test_back_to_back();
    test_random_traffic();

    wait_for_results();
    repeat (20) @(posedge clk);   // catch any stray result

    if (fail_count == 0 && expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #3ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
